[design/crld_pkg.sv]
package crld_pkg;

	localparam int MAX_FIELD_BYTES = 8;
	localparam int BPC_W           = 22;
	localparam int START_W         = 63;
	localparam int COUNT_W         = 64;
	localparam logic [BPC_W-1:0] BPC_RESET = 22'd4096;

	// result classes
	typedef enum logic [1:0] {
		KIND_RUN = 2'd0,
		KIND_END = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// run list decode phases
	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DELTA  = 2'd2,
		PH_WAIT   = 2'd3
	} phase_t;

	// decoded run handed from the parser to the byte scaler
	typedef struct packed {
		kind_t               kind;
		logic [START_W-1:0]  start;
		logic [COUNT_W-1:0]  clusters;
	} run_res_t;

endpackage

[design/crld_in_if.sv]
interface crld_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] run_byte;
	logic       list_start;

	modport source (output valid, output run_byte, output list_start, input ready);
	modport sink   (input valid, input run_byte, input list_start, output ready);
endinterface

[design/crld_out_if.sv]
interface crld_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [62:0] run_start_cluster;
	logic [63:0] run_clusters;
	logic [63:0] run_bytes;

	modport source (output valid, output kind, output run_start_cluster,
		output run_clusters, output run_bytes, input ready);
	modport sink   (input valid, input kind, input run_start_cluster,
		input run_clusters, input run_bytes, output ready);
endinterface

[design/crld_cfg_if.sv]
interface crld_cfg_if;
	logic        valid;
	logic        ready;
	logic [21:0] bytes_per_cluster;

	modport source (output valid, output bytes_per_cluster, input ready);
	modport sink   (input valid, input bytes_per_cluster, output ready);
endinterface

[design/crld_parse.sv]
module crld_parse (
	input  logic               clk,
	input  logic               arst_n,
	crld_in_if.sink            run_in,
	output logic               res_valid,
	output crld_pkg::run_res_t res,
	input  logic               res_ready
);
	import crld_pkg::*;

	phase_t             phase_q;
	logic [3:0]         lsz_q, dsz_q, cnt_q;
	logic [63:0]        len_q, dlt_q, clu_q;

	phase_t             ph_n;
	logic [3:0]         lsz_n, dsz_n, cnt_n;
	logic [63:0]        len_n, dlt_n, clu_n;

	phase_t             cur_ph;
	logic [63:0]        cur_clu;
	logic [63:0]        shifted;
	logic [3:0]         cnt_inc;
	logic [63:0]        fin_delta;
	logic [63:0]        next_clu;
	logic               take;
	logic               res_v_n;
	run_res_t           res_n;

	logic               s1_v;
	run_res_t           res_s1;

	// sign extend an offset field of n bytes
	function automatic logic [63:0] sext_delta(input logic [63:0] d, input logic [3:0] n);
		logic [63:0] r;
		r = d;
		case (n)
			4'd1: if (d[7])  r[63:8]  = '1;
			4'd2: if (d[15]) r[63:16] = '1;
			4'd3: if (d[23]) r[63:24] = '1;
			4'd4: if (d[31]) r[63:32] = '1;
			4'd5: if (d[39]) r[63:40] = '1;
			4'd6: if (d[47]) r[63:48] = '1;
			4'd7: if (d[55]) r[63:56] = '1;
			default: r = d;
		endcase
		return r;
	endfunction

	// input handshake
	assign run_in.ready = !s1_v || res_ready;
	assign take         = run_in.valid && run_in.ready;

	// list start restarts the decode at cluster zero
	assign cur_ph    = run_in.list_start ? PH_HEADER : phase_q;
	assign cur_clu   = run_in.list_start ? 64'd0 : clu_q;
	assign shifted   = {56'd0, run_in.run_byte} << {cnt_q[2:0], 3'b000};
	assign cnt_inc   = cnt_q + 4'd1;
	assign fin_delta = (cur_ph == PH_DELTA) ? (dlt_q | shifted) : dlt_q;
	assign next_clu  = cur_clu + sext_delta(fin_delta, dsz_q);

	// next state and result
	always_comb begin
		ph_n    = phase_q;
		lsz_n   = lsz_q;
		dsz_n   = dsz_q;
		cnt_n   = cnt_q;
		len_n   = len_q;
		dlt_n   = dlt_q;
		clu_n   = clu_q;
		res_v_n = 1'b0;
		res_n   = '{kind: KIND_RUN, start: '0, clusters: '0};
		if (take) begin
			logic       finish;
			logic [63:0] fin_len;
			finish  = 1'b0;
			fin_len = len_q;
			clu_n   = cur_clu;
			ph_n    = cur_ph;
			case (cur_ph)
				PH_HEADER: begin
					if (run_in.run_byte == 8'd0) begin
						ph_n       = PH_WAIT;
						res_v_n    = 1'b1;
						res_n.kind = KIND_END;
					end else if (run_in.run_byte[3:0] > 4'(MAX_FIELD_BYTES) ||
							run_in.run_byte[7:4] > 4'(MAX_FIELD_BYTES)) begin
						ph_n       = PH_WAIT;
						res_v_n    = 1'b1;
						res_n.kind = KIND_ERR;
					end else begin
						lsz_n = run_in.run_byte[3:0];
						dsz_n = run_in.run_byte[7:4];
						len_n = '0;
						dlt_n = '0;
						cnt_n = '0;
						ph_n  = (run_in.run_byte[3:0] != 4'd0) ? PH_LENGTH : PH_DELTA;
					end
				end
				PH_LENGTH: begin
					len_n = len_q | shifted;
					cnt_n = cnt_inc;
					if (cnt_inc >= lsz_q) begin
						cnt_n = '0;
						if (dsz_q == 4'd0) begin
							finish  = 1'b1;
							fin_len = len_q | shifted;
						end else begin
							ph_n = PH_DELTA;
						end
					end
				end
				PH_DELTA: begin
					dlt_n = dlt_q | shifted;
					cnt_n = cnt_inc;
					if (cnt_inc >= dsz_q) begin
						cnt_n  = '0;
						finish = 1'b1;
					end
				end
				default: ;
			endcase
			// run complete: move the running cluster or flag a bad start
			if (finish) begin
				res_v_n = 1'b1;
				if (next_clu[63]) begin
					ph_n       = PH_WAIT;
					res_n.kind = KIND_ERR;
				end else begin
					clu_n          = next_clu;
					ph_n           = PH_HEADER;
					res_n.start    = next_clu[62:0];
					res_n.clusters = fin_len;
				end
			end
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			lsz_q   <= '0;
			dsz_q   <= '0;
			cnt_q   <= '0;
			len_q   <= '0;
			dlt_q   <= '0;
			clu_q   <= '0;
		end else begin
			phase_q <= ph_n;
			lsz_q   <= lsz_n;
			dsz_q   <= dsz_n;
			cnt_q   <= cnt_n;
			len_q   <= len_n;
			dlt_q   <= dlt_n;
			clu_q   <= clu_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (run_in.ready) begin
			s1_v <= take && res_v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (run_in.ready) begin
			res_s1 <= res_n;
		end
	end

	assign res_valid = s1_v;
	assign res       = res_s1;

	// end or error results always park the decoder
	a_park: assert property (@(posedge clk) disable iff (!arst_n)
		(take && res_v_n && res_n.kind != KIND_RUN) |=> phase_q == PH_WAIT)
		else $error("decoder not parked after end or error result");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 4'(MAX_FIELD_BYTES))
		else $error("field byte count out of range");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_v && !res_ready) |=> (s1_v && $stable(res_s1)))
		else $error("stalled stage 1 result changed");

endmodule

[design/crld_scale.sv]
module crld_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	input  crld_pkg::run_res_t res,
	output logic               res_ready,
	input  logic [21:0]        bytes_per_cluster,
	crld_out_if.source         run_out
);
	import crld_pkg::*;

	logic               s2_v;
	kind_t              kind_s2;
	logic [START_W-1:0] start_s2;
	logic [COUNT_W-1:0] clu_s2;
	logic [53:0]        plo_s2, phi_s2;

	logic               s3_v;
	kind_t              kind_s3;
	logic [START_W-1:0] start_s3;
	logic [COUNT_W-1:0] clu_s3;
	logic [63:0]        bytes_s3;

	logic               s3_en;
	logic [53:0]        plo, phi;
	logic [64:0]        sum;
	logic               ovf;

	// stall chain
	assign s3_en     = !s3_v || run_out.ready;
	assign res_ready = !s2_v || s3_en;

	// two 32 x 22 partial products of the run length
	assign plo = 54'(res.clusters[31:0]) * 54'(bytes_per_cluster);
	assign phi = 54'(res.clusters[63:32]) * 54'(bytes_per_cluster);

	// recombine, saturating at all ones
	assign sum = {11'd0, plo_s2} + {1'b0, phi_s2[31:0], 32'd0};
	assign ovf = (|phi_s2[53:32]) || sum[64];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
			s3_v <= 1'b0;
		end else begin
			if (res_ready) s2_v <= res_valid;
			if (s3_en)     s3_v <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready) begin
			kind_s2  <= res.kind;
			start_s2 <= res.start;
			clu_s2   <= res.clusters;
			plo_s2   <= plo;
			phi_s2   <= phi;
		end
		if (s3_en) begin
			kind_s3  <= kind_s2;
			start_s3 <= start_s2;
			clu_s3   <= clu_s2;
			bytes_s3 <= ovf ? '1 : sum[63:0];
		end
	end

	// output transaction
	assign run_out.valid             = s3_v;
	assign run_out.kind              = kind_s3;
	assign run_out.run_start_cluster = start_s3;
	assign run_out.run_clusters      = clu_s3;
	assign run_out.run_bytes         = bytes_s3;

	a_zero_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(s3_v && (kind_s3 != KIND_RUN || clu_s3 == '0)) |-> bytes_s3 == '0)
		else $error("byte count nonzero for empty run or non-run result");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v && !s3_en) |=> (s2_v && $stable(plo_s2) && $stable(phi_s2)))
		else $error("stalled stage 2 products changed");

endmodule

[design/cluster_run_list_decoder.sv]
// Run list decoder: takes one byte of a non-resident attribute's run list per
// clock on run_in and, for each completed run, end marker or malformed entry,
// returns one transaction on run_out with the absolute start cluster, the
// length in clusters and the length in bytes (saturating at all ones). A byte
// is accepted every cycle while the output keeps up; a result is registered in
// the parser register, then the stage holding the two 32 x 22 partial products
// of length times cluster size, then the output register that recombines them.
// Assert list_start with the first header of each list to restart from cluster
// zero. The user must write bytes_per_cluster through cfg only while no
// transaction is in flight; the block enforces none of this. Reset value 4096.
module cluster_run_list_decoder (
	input  logic       clk,
	input  logic       arst_n,
	crld_in_if.sink    run_in,
	crld_out_if.source run_out,
	crld_cfg_if.sink   cfg
);
	import crld_pkg::*;

	logic [BPC_W-1:0] bpc_q;
	logic             res_valid;
	logic             res_ready;
	run_res_t         res;

	// cluster size register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q <= BPC_RESET;
		end else if (cfg.valid) begin
			bpc_q <= cfg.bytes_per_cluster;
		end
	end

	crld_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.run_in    (run_in),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	crld_scale u_scale (
		.clk               (clk),
		.arst_n            (arst_n),
		.res_valid         (res_valid),
		.res               (res),
		.res_ready         (res_ready),
		.bytes_per_cluster (bpc_q),
		.run_out           (run_out)
	);

endmodule

[test/tb.sv]
module tb;
	import crld_pkg::*;

	// one expected decoder result
	typedef struct {
		kind_t              kind;
		logic [START_W-1:0] start;
		logic [COUNT_W-1:0] clusters;
		logic [COUNT_W-1:0] byte_len;
	} run_result_t;

	// one run list byte to send
	typedef struct {
		logic [7:0] run_byte;
		logic       list_start;
	} list_byte_t;

	// run list decode tracker: mirrors the decoder state and holds expected runs
	class run_decode_tracker;
		logic [BPC_W-1:0]   cluster_bytes;
		phase_t             phase;
		logic [3:0]         len_size;
		logic [3:0]         off_size;
		logic [3:0]         field_idx;
		logic [63:0]        len_acc;
		logic [63:0]        off_acc;
		logic [63:0]        cursor;
		run_result_t        expected_runs[$];
		int                 errors;

		function new();
			cluster_bytes = BPC_RESET;
			phase = PH_HEADER;
			len_size = '0;
			off_size = '0;
			field_idx = '0;
			len_acc = '0;
			off_acc = '0;
			cursor = '0;
			errors = 0;
		endfunction

		function void push_run(kind_t k, logic [START_W-1:0] s, logic [COUNT_W-1:0] c,
			logic [COUNT_W-1:0] b);
			run_result_t r;
			r.kind = k;
			r.start = s;
			r.clusters = c;
			r.byte_len = b;
			expected_runs.push_back(r);
		endfunction

		// sign-extend the delta, move the cursor, scale the length to bytes
		function void close_run();
			logic [63:0]  delta;
			logic [63:0]  new_start;
			logic [127:0] prod;
			int           sh;
			delta = off_acc;
			if (off_size >= 1 && off_size <= 7) begin
				sh = 8 * off_size;
				if (delta[sh-1])
					delta = delta | (~64'd0 << sh);
			end
			new_start = cursor + delta;
			if (new_start[63]) begin
				phase = PH_WAIT;
				push_run(KIND_ERR, '0, '0, '0);
				return;
			end
			cursor = new_start;
			phase = PH_HEADER;
			prod = 128'(len_acc) * 128'(cluster_bytes);
			push_run(KIND_RUN, new_start[START_W-1:0], len_acc,
				(prod[127:64] != 0) ? {COUNT_W{1'b1}} : prod[63:0]);
		endfunction

		// note one accepted input transaction
		function void note_byte(logic [7:0] b, logic ls);
			if (ls) begin
				cursor = '0;
				phase = PH_HEADER;
			end
			case (phase)
				PH_HEADER: begin
					if (b == 8'd0) begin
						phase = PH_WAIT;
						push_run(KIND_END, '0, '0, '0);
					end else begin
						len_size = b[3:0];
						off_size = b[7:4];
						if (len_size > MAX_FIELD_BYTES || off_size > MAX_FIELD_BYTES) begin
							phase = PH_WAIT;
							push_run(KIND_ERR, '0, '0, '0);
						end else begin
							len_acc = '0;
							off_acc = '0;
							field_idx = '0;
							phase = (len_size != 0) ? PH_LENGTH : PH_DELTA;
						end
					end
				end
				PH_LENGTH: begin
					len_acc = len_acc | (64'(b) << (8 * field_idx[2:0]));
					field_idx = field_idx + 4'd1;
					if (field_idx >= len_size) begin
						field_idx = '0;
						if (off_size == 0)
							close_run();
						else
							phase = PH_DELTA;
					end
				end
				PH_DELTA: begin
					off_acc = off_acc | (64'(b) << (8 * field_idx[2:0]));
					field_idx = field_idx + 4'd1;
					if (field_idx >= off_size) begin
						field_idx = '0;
						close_run();
					end
				end
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_runs.size();
		endfunction

		task report(string msg);
			$display("tb: mismatch at %0t: %s", $time, msg);
			errors++;
		endtask

		// compare one output transaction with the oldest expected run
		task check_result(logic [1:0] k, logic [START_W-1:0] s, logic [COUNT_W-1:0] c,
			logic [COUNT_W-1:0] b);
			run_result_t r;
			if (expected_runs.size() == 0) begin
				report($sformatf("unexpected result kind %0d", k));
				return;
			end
			r = expected_runs.pop_front();
			if (k !== r.kind)
				report($sformatf("kind %0d, expected %0d", k, r.kind));
			if (s !== r.start)
				report($sformatf("start cluster %0h, expected %0h", s, r.start));
			if (c !== r.clusters)
				report($sformatf("clusters %0h, expected %0h", c, r.clusters));
			if (b !== r.byte_len)
				report($sformatf("bytes %0h, expected %0h", b, r.byte_len));
		endtask
	endclass

	logic clk;
	logic arst_n;
	bit   calm;

	crld_in_if  run_in_if();
	crld_out_if run_out_if();
	crld_cfg_if cfg_if();

	cluster_run_list_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.run_in  (run_in_if),
		.run_out (run_out_if),
		.cfg     (cfg_if)
	);

	run_decode_tracker tracker = new();
	list_byte_t        byte_q[$];

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// watchdog
	initial begin
		#1000000;
		$display("tb: done, errors");
		$finish;
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && run_out_if.valid && run_out_if.ready)
			tracker.check_result(run_out_if.kind, run_out_if.run_start_cluster,
				run_out_if.run_clusters, run_out_if.run_bytes);
	end

	// receiver stalls in random bursts
	initial begin
		run_out_if.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!calm && $urandom_range(0, 4) == 0) begin
				run_out_if.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			run_out_if.ready <= 1'b1;
			@(posedge clk);
		end
	end

	function automatic void add_byte(logic [7:0] b, logic ls);
		list_byte_t x;
		x.run_byte = b;
		x.list_start = ls;
		byte_q.push_back(x);
	endfunction

	// field sizes: mostly short, sometimes empty or full width
	function automatic int pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 0;
		if (r < 75)
			return $urandom_range(1, 3);
		return $urandom_range(4, 8);
	endfunction

	// well-formed run list, sometimes cut short inside a run
	function automatic int gen_list();
		int         runs;
		int         cut_run;
		int         keep;
		int         ln;
		int         dn;
		int         cnt;
		logic [7:0] b;
		cnt = 0;
		runs = $urandom_range(1, 6);
		cut_run = ($urandom_range(0, 9) == 0) ? $urandom_range(0, runs - 1) : -1;
		for (int r = 0; r < runs; r++) begin
			ln = pick_size();
			dn = pick_size();
			if (ln == 0 && dn == 0)
				ln = 1;
			add_byte({dn[3:0], ln[3:0]}, cnt == 0);
			cnt++;
			keep = (r == cut_run) ? $urandom_range(0, ln + dn - 1) : ln + dn;
			for (int j = 0; j < keep; j++) begin
				b = 8'($urandom_range(0, 255));
				// first delta of a list stays positive so the list gets going
				if (r == 0 && j == ln + dn - 1)
					b[7] = 1'b0;
				add_byte(b, 1'b0);
				cnt++;
			end
			if (r == cut_run)
				return cnt;
		end
		if ($urandom_range(0, 4) != 0) begin
			add_byte(8'h00, 1'b0);
			cnt++;
			// trailing bytes after the end marker are ignored
			repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)), 1'b0);
		end
		return cnt;
	endfunction

	// oversized headers and raw random bytes
	function automatic int gen_noise();
		int         n;
		logic [7:0] b;
		if ($urandom_range(0, 1) == 0) begin
			b = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 1) == 0)
				b[3:0] = 4'($urandom_range(9, 15));
			else
				b[7:4] = 4'($urandom_range(9, 15));
			add_byte(b, 1'b1);
			return 1;
		end
		n = $urandom_range(1, 6);
		repeat (n) add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
		return n;
	endfunction

	task automatic build_random(input int target);
		int n;
		n = 0;
		while (n < target) begin
			if ($urandom_range(0, 99) < 85)
				n += gen_list();
			else
				n += gen_noise();
		end
	endtask

	// drive queued bytes, gaps in random bursts
	task automatic send_bytes();
		list_byte_t x;
		while (byte_q.size() != 0) begin
			x = byte_q.pop_front();
			if (!calm && $urandom_range(0, 4) == 0) begin
				run_in_if.valid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			run_in_if.valid <= 1'b1;
			run_in_if.run_byte <= x.run_byte;
			run_in_if.list_start <= x.list_start;
			do @(posedge clk); while (!run_in_if.ready);
			tracker.note_byte(x.run_byte, x.list_start);
		end
		run_in_if.valid <= 1'b0;
	endtask

	// wait out every expected result plus the pipeline depth
	task automatic drain();
		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_cluster_size(input logic [BPC_W-1:0] v);
		cfg_if.valid <= 1'b1;
		cfg_if.bytes_per_cluster <= v;
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		tracker.cluster_bytes = v;
	endtask

	// main sequence
	initial begin
		logic [BPC_W-1:0] sizes[6];
		sizes[0] = 22'd512;
		sizes[1] = 22'd2097152;
		sizes[2] = 22'h3FFFFF;
		sizes[3] = 22'd0;
		sizes[4] = 22'($urandom_range(512, 2097152));
		sizes[5] = BPC_RESET;
		calm = 1'b0;
		arst_n <= 1'b0;
		run_in_if.valid <= 1'b0;
		run_in_if.run_byte <= 8'h00;
		run_in_if.list_start <= 1'b0;
		cfg_if.valid <= 1'b0;
		cfg_if.bytes_per_cluster <= BPC_RESET;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// list with no list start after reset: run at 127, 255 clusters
		add_byte(8'h11, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h7F, 1'b0);
		// delta of -128 takes the start below zero
		add_byte(8'h10, 1'b0);
		add_byte(8'h80, 1'b0);
		// ignored while waiting for list start
		add_byte(8'h55, 1'b0);
		// length field too wide
		add_byte(8'h0F, 1'b1);
		// full width fields: all-ones length, largest positive start
		add_byte(8'h88, 1'b1);
		repeat (8) add_byte(8'hFF, 1'b0);
		repeat (7) add_byte(8'hFF, 1'b0);
		add_byte(8'h7F, 1'b0);
		// list start mid-run, then zero length with no offset, then end
		add_byte(8'h21, 1'b1);
		add_byte(8'h05, 1'b0);
		add_byte(8'h01, 1'b1);
		add_byte(8'h00, 1'b0);
		add_byte(8'h00, 1'b0);
		send_bytes();
		drain();

		// random lists across cluster sizes, last phase without stalls
		for (int p = 0; p < 6; p++) begin
			calm = (p == 5);
			write_cluster_size(sizes[p]);
			build_random(280);
			send_bytes();
			drain();
		end

		if (tracker.errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule
